// ===== rtl/iorl_pkg.sv =====
// Shared widths, codes and control structs for the I/O rate limiter delay unit.
package iorl_pkg;

   localparam int BytesW   = 32;
   localparam int TicksW   = 40;
   localparam int TotalW   = 48;
   localparam int CountW   = 32;
   localparam int RegW     = 32;
   localparam int DivW     = 80;
   localparam int DivisorW = 32;
   localparam int StepW    = $clog2(DivW + 1);

   localparam logic [0:0] CsrBytesPerPeriod = 1'b0;
   localparam logic [0:0] CsrPeriodTicks    = 1'b1;

   localparam logic [RegW-1:0] RateReset   = 32'd1000;
   localparam logic [RegW-1:0] PeriodReset = 32'd1000000;

   localparam logic [StepW-1:0] StepsTicks = StepW'(TicksW);
   localparam logic [StepW-1:0] StepsTotal = StepW'(TotalW);
   localparam logic [StepW-1:0] StepsFull  = StepW'(DivW);

   typedef struct packed {
      logic                start;
      logic [DivW-1:0]     dividend;
      logic [DivisorW-1:0] divisor;
      logic [StepW-1:0]    steps;
   } div_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [DivW-1:0]     quotient;
      logic [DivisorW-1:0] remainder;
   } div_rsp_type;

   typedef enum logic [9:0] {
      StIdle    = 10'b0000000001,
      StDivPer  = 10'b0000000010,
      StDivRate = 10'b0000000100,
      StMulLo   = 10'b0000001000,
      StMulHi   = 10'b0000010000,
      StMulAdd  = 10'b0000100000,
      StDivCnt  = 10'b0001000000,
      StDivCur  = 10'b0010000000,
      StAccum   = 10'b0100000000,
      StResp    = 10'b1000000000
   } state_type;

endpackage

// ===== rtl/iorl_if.sv =====
// Valid/ready channel interfaces for I/O events and delay results.
interface iorl_req_if
   import iorl_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BytesW-1:0] bytes_read;
   logic [TicksW-1:0] elapsed_ticks;

   modport source (output valid, bytes_read, elapsed_ticks, input ready);
   modport sink (input valid, bytes_read, elapsed_ticks, output ready);
endinterface

interface iorl_rsp_if
   import iorl_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [TicksW-1:0] delay_ticks;
   logic              inconsistent;
   logic [TotalW-1:0] total_bytes;
   logic [CountW-1:0] io_count;
   logic [TotalW-1:0] total_delay;

   modport source (output valid, delay_ticks, inconsistent, total_bytes, io_count,
                   total_delay, input ready);
   modport sink (input valid, delay_ticks, inconsistent, total_bytes, io_count,
                 total_delay, output ready);
endinterface

// ===== rtl/iorl_div.sv =====
// Shared restoring divider that produces one quotient bit per cycle.
module iorl_div
   import iorl_pkg::*;
   (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DivW-1:0]     dq_ff, dq_in;
   logic [DivisorW-1:0] rem_ff, rem_in;
   logic [DivisorW-1:0] dvs_ff;
   logic [StepW-1:0]    cnt_ff;
   logic                busy_ff, done_ff;
   logic [DivisorW:0]   shifted;
   logic [DivisorW:0]   diff;
   logic                ge;

   always_comb begin
      shifted = {rem_ff, dq_ff[DivW-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = shifted >= {1'b0, dvs_ff};
      rem_in  = ge ? diff[DivisorW-1:0] : shifted[DivisorW-1:0];
      dq_in   = {dq_ff[DivW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= div_req.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - StepW'(1);
            if (cnt_ff == StepW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         dq_ff  <= div_req.dividend;
         rem_ff <= '0;
         dvs_ff <= div_req.divisor;
      end else if (busy_ff) begin
         dq_ff  <= dq_in;
         rem_ff <= rem_in;
      end
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = dq_ff;
   assign div_rsp.remainder = rem_ff;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("Divider started while busy.");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("Divider done while still busy.");

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0))
      else $error("Divider busy with no steps left.");
`endif

endmodule

// ===== rtl/io_rate_limiter_delay_unit.sv =====
// Top level of the I/O rate limiter delay unit with its sequencer and statistics.
// The result is presented after the full delay computation when the byte total
// exceeds the allowance, and after the first two divisions only when it does not; the work is done by
// one shared divider that yields one quotient bit per cycle, used for elapsed / period
// (40 steps), total / rate (48 steps), needed duration / count (80 steps) and
// elapsed / count (40 steps), plus a 32 by 32 multiplier used twice. A new event is
// taken only after the previous result has been transferred.
module io_rate_limiter_delay_unit
   import iorl_pkg::*;
   (
   input  logic              clock,
   input  logic              reset,
   iorl_req_if.sink          req_chan,
   iorl_rsp_if.source        rsp_chan,
   input  logic              csr_wr_en,
   input  logic [0:0]        csr_index,
   input  logic [RegW-1:0]   csr_wdata
);

   state_type           state_ff, state_in;
   logic [RegW-1:0]     rate_cfg_ff, per_cfg_ff;
   logic [RegW-1:0]     rate_ff, per_ff;
   logic [RegW-1:0]     rate_in, per_in;
   logic [TicksW-1:0]   elapsed_ff;
   logic [CountW-1:0]   count_ff, count_in;
   logic [TotalW-1:0]   total_ff, total_in;
   logic [TotalW-1:0]   dtotal_ff;
   logic [TicksW:0]     periods_ff;
   logic [TotalW-1:0]   qt_ff;
   logic [63:0]         mlo_ff;
   logic [TotalW-1:0]   mhi_ff;
   logic [DivW-1:0]     needed_ff;
   logic [TicksW-1:0]   delay_ff;
   logic                incons_ff;
   logic                accept;
   logic [TotalW:0]     total_sum;
   logic [TotalW:0]     dtotal_sum;
   logic [RegW-1:0]     mul_a;
   logic [63:0]         mul_p;
   logic [TotalW-1:0]   qt;
   logic                over;
   logic                fits;
   logic [63:0]         needed64;
   logic [63:0]         diff;
   logic [TicksW-1:0]   cur;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   iorl_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == StIdle);

   always_comb begin
      rate_in   = (rate_cfg_ff == '0) ? RegW'(1) : rate_cfg_ff;
      per_in    = (per_cfg_ff == '0) ? RegW'(1) : per_cfg_ff;
      count_in  = (count_ff == '1) ? count_ff : count_ff + CountW'(1);
      total_sum = {1'b0, total_ff} + {{(TotalW + 1 - BytesW){1'b0}}, req_chan.bytes_read};
      total_in  = total_sum[TotalW] ? '1 : total_sum[TotalW-1:0];
      qt        = div_rsp.quotient[TotalW-1:0];
      over      = (qt > {{(TotalW - TicksW - 1){1'b0}}, periods_ff})
                  || ((qt == {{(TotalW - TicksW - 1){1'b0}}, periods_ff})
                      && (div_rsp.remainder != '0));
      mul_a     = (state_ff == StMulLo) ? qt_ff[RegW-1:0]
                                        : {{(2 * RegW - TotalW){1'b0}}, qt_ff[TotalW-1:RegW]};
      mul_p     = mul_a * per_ff;
      fits      = (needed_ff[DivW-1:64] == '0);
      needed64  = needed_ff[63:0];
      cur       = div_rsp.quotient[TicksW-1:0];
      diff      = needed64 - {{(64 - TicksW){1'b0}}, cur};
      dtotal_sum = {1'b0, dtotal_ff} + {{(TotalW + 1 - TicksW){1'b0}}, delay_ff};
   end

   always_comb begin
      state_in         = state_ff;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      div_req.steps    = '0;
      case (state_ff)
         StIdle: begin
            if (accept) begin
               div_req.start    = 1'b1;
               div_req.dividend = {req_chan.elapsed_ticks, {(DivW - TicksW){1'b0}}};
               div_req.divisor  = per_in;
               div_req.steps    = StepsTicks;
               state_in         = StDivPer;
            end
         end
         StDivPer: begin
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = {total_ff, {(DivW - TotalW){1'b0}}};
               div_req.divisor  = rate_ff;
               div_req.steps    = StepsTotal;
               state_in         = StDivRate;
            end
         end
         StDivRate: begin
            if (div_rsp.done) begin
               state_in = over ? StMulLo : StAccum;
            end
         end
         StMulLo: state_in = StMulHi;
         StMulHi: state_in = StMulAdd;
         StMulAdd: begin
            div_req.start    = 1'b1;
            div_req.dividend = {{(DivW - 64){1'b0}}, mlo_ff}
                               + {mhi_ff, {(DivW - TotalW){1'b0}}};
            div_req.divisor  = count_ff;
            div_req.steps    = StepsFull;
            state_in         = StDivCnt;
         end
         StDivCnt: begin
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = {elapsed_ff, {(DivW - TicksW){1'b0}}};
               div_req.divisor  = count_ff;
               div_req.steps    = StepsTicks;
               state_in         = StDivCur;
            end
         end
         StDivCur: begin
            if (div_rsp.done) begin
               state_in = StAccum;
            end
         end
         StAccum: state_in = StResp;
         StResp: begin
            if (rsp_chan.ready) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= StIdle;
         rate_cfg_ff <= RateReset;
         per_cfg_ff  <= PeriodReset;
         count_ff    <= '0;
         total_ff    <= '0;
         dtotal_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            case (csr_index)
               CsrBytesPerPeriod: rate_cfg_ff <= csr_wdata;
               CsrPeriodTicks:    per_cfg_ff  <= csr_wdata;
               default:           rate_cfg_ff <= rate_cfg_ff;
            endcase
         end
         if (accept) begin
            count_ff <= count_in;
            total_ff <= total_in;
         end
         if (state_ff == StAccum) begin
            dtotal_ff <= dtotal_sum[TotalW] ? '1 : dtotal_sum[TotalW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rate_ff    <= rate_in;
         per_ff     <= per_in;
         elapsed_ff <= req_chan.elapsed_ticks;
      end
      if (state_ff == StDivPer && div_rsp.done) begin
         periods_ff <= {1'b0, div_rsp.quotient[TicksW-1:0]} + (TicksW + 1)'(1);
      end
      if (state_ff == StDivRate && div_rsp.done) begin
         qt_ff     <= qt;
         delay_ff  <= '0;
         incons_ff <= 1'b0;
      end
      if (state_ff == StMulLo) begin
         mlo_ff <= mul_p;
      end
      if (state_ff == StMulHi) begin
         mhi_ff <= mul_p[TotalW-1:0];
      end
      if (state_ff == StDivCnt && div_rsp.done) begin
         needed_ff <= div_rsp.quotient;
      end
      if (state_ff == StDivCur && div_rsp.done) begin
         if (fits && (needed64 < {{(64 - TicksW){1'b0}}, cur})) begin
            incons_ff <= 1'b1;
            delay_ff  <= '0;
         end else if (!fits || (diff[63:TicksW] != '0)) begin
            incons_ff <= 1'b0;
            delay_ff  <= '1;
         end else begin
            incons_ff <= 1'b0;
            delay_ff  <= diff[TicksW-1:0];
         end
      end
   end

   assign rsp_chan.valid        = (state_ff == StResp);
   assign rsp_chan.delay_ticks  = delay_ff;
   assign rsp_chan.inconsistent = incons_ff;
   assign rsp_chan.total_bytes  = total_ff;
   assign rsp_chan.io_count     = count_ff;
   assign rsp_chan.total_delay  = dtotal_ff;

`ifndef SYNTHESIS
   a_incons_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && incons_ff) |-> (delay_ff == '0))
      else $error("Inconsistent result carries a nonzero delay.");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      accept |-> !rsp_chan.valid)
      else $error("Event transfer while a result is pending.");

   a_div_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !div_rsp.busy)
      else $error("Divider busy while a result is presented.");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the I/O rate limiter delay unit.
module tb;
   import iorl_pkg::*;

   localparam int CycleLimit = 1000000;
   localparam int SumW = TotalW + 1;
   localparam int HoldCycles = 3000;
   localparam logic [TicksW-1:0] TicksMax = '1;
   localparam logic [RegW-1:0] RegMax = '1;

   typedef struct packed {
      logic [TicksW-1:0] delay_ticks;
      logic              inconsistent;
      logic [TotalW-1:0] total_bytes;
      logic [CountW-1:0] io_count;
      logic [TotalW-1:0] total_delay;
   } delay_result_t;

   typedef enum logic {RowEvent, RowCsr} row_kind_t;

   typedef struct packed {
      row_kind_t         kind;
      logic [0:0]        index;
      logic [RegW-1:0]   value;
      logic [TicksW-1:0] elapsed;
      logic              pinned;
      delay_result_t     want;
   } row_t;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [0:0] csr_index;
   logic [RegW-1:0] csr_wdata;

   iorl_req_if req_chan ();
   iorl_rsp_if rsp_chan ();

   io_rate_limiter_delay_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [RegW-1:0]   cfg_rate = RateReset;
   logic [RegW-1:0]   cfg_period = PeriodReset;
   logic [CountW-1:0] pred_count = '0;
   logic [TotalW-1:0] pred_bytes = '0;
   logic [TotalW-1:0] pred_delay = '0;
   logic [TicksW-1:0] tick_now = '0;

   delay_result_t pending_results[$];
   delay_result_t pin_result;
   logic pin_armed = 1'b0;

   int err_count = 0;
   int results_seen = 0;
   int events_taken = 0;
   int delayed_events = 0;
   int ceiling_events = 0;
   int settings_used = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;

   row_t directed_rows [21] = '{
      '{RowEvent, CsrBytesPerPeriod, 32'd0, 40'd0, 1'b1,
        '{40'd0, 1'b0, 48'd0, 32'd1, 48'd0}},
      '{RowEvent, CsrBytesPerPeriod, 32'd1000, 40'd0, 1'b1,
        '{40'd0, 1'b0, 48'd1000, 32'd2, 48'd0}},
      '{RowEvent, CsrBytesPerPeriod, 32'd1, 40'd0, 1'b1,
        '{40'd333333, 1'b0, 48'd1001, 32'd3, 48'd333333}},
      '{RowEvent, CsrBytesPerPeriod, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b0, '0},
      '{RowEvent, CsrBytesPerPeriod, 32'd0, 40'hFF_FFFF_FFFF, 1'b0, '0},
      '{RowEvent, CsrBytesPerPeriod, 32'd500, 40'd5000000, 1'b0, '0},
      '{RowCsr, CsrBytesPerPeriod, 32'd0, 40'd0, 1'b0, '0},
      '{RowCsr, CsrPeriodTicks, 32'd0, 40'd0, 1'b0, '0},
      '{RowEvent, CsrBytesPerPeriod, 32'd0, 40'd0, 1'b0, '0},
      '{RowEvent, CsrBytesPerPeriod, 32'd7, 40'hFF_FFFF_FFFF, 1'b0, '0},
      '{RowEvent, CsrBytesPerPeriod, 32'hFFFF_FFFF, 40'd1, 1'b0, '0},
      '{RowCsr, CsrBytesPerPeriod, 32'hFFFF_FFFF, 40'd0, 1'b0, '0},
      '{RowCsr, CsrPeriodTicks, 32'hFFFF_FFFF, 40'd0, 1'b0, '0},
      '{RowEvent, CsrBytesPerPeriod, 32'hFFFF_FFFF, 40'd0, 1'b0, '0},
      '{RowEvent, CsrBytesPerPeriod, 32'd1, 40'hFF_FFFF_FFFF, 1'b0, '0},
      '{RowCsr, CsrBytesPerPeriod, 32'd1, 40'd0, 1'b0, '0},
      '{RowCsr, CsrPeriodTicks, 32'hFFFF_FFFF, 40'd0, 1'b0, '0},
      '{RowEvent, CsrBytesPerPeriod, 32'hFFFF_FFFF, 40'd0, 1'b0, '0},
      '{RowEvent, CsrBytesPerPeriod, 32'd0, 40'hFF_FFFF_FFFF, 1'b0, '0},
      '{RowEvent, CsrBytesPerPeriod, 32'h5555_5555, 40'hAA_AAAA_AAAA, 1'b0, '0},
      '{RowEvent, CsrBytesPerPeriod, 32'hAAAA_AAAA, 40'h55_5555_5555, 1'b0, '0}
   };

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic delay_result_t limiter_predict(input logic [BytesW-1:0] nbytes,
                                                     input logic [TicksW-1:0] elapsed);
      logic [127:0] rate_eff;
      logic [127:0] per_eff;
      logic [127:0] allowance;
      logic [127:0] needed;
      logic [127:0] cur_dur;
      logic [127:0] diff;
      logic [SumW-1:0] sum;
      delay_result_t r;
      rate_eff = (cfg_rate == '0) ? 128'd1 : 128'(cfg_rate);
      per_eff = (cfg_period == '0) ? 128'd1 : 128'(cfg_period);
      r = '0;
      if (pred_count != '1) pred_count = pred_count + CountW'(1);
      sum = SumW'(pred_bytes) + SumW'(nbytes);
      pred_bytes = sum[TotalW] ? '1 : sum[TotalW-1:0];
      allowance = rate_eff * (128'(elapsed) / per_eff + 128'd1);
      if (128'(pred_bytes) > allowance) begin
         needed = ((128'(pred_bytes) / rate_eff) * per_eff) / 128'(pred_count);
         cur_dur = 128'(elapsed) / 128'(pred_count);
         if (needed < cur_dur) begin
            r.inconsistent = 1'b1;
         end else begin
            diff = needed - cur_dur;
            r.delay_ticks = (diff > 128'(TicksMax)) ? TicksMax : diff[TicksW-1:0];
            sum = SumW'(pred_delay) + SumW'(r.delay_ticks);
            pred_delay = sum[TotalW] ? '1 : sum[TotalW-1:0];
         end
      end
      r.total_bytes = pred_bytes;
      r.io_count = pred_count;
      r.total_delay = pred_delay;
      return r;
   endfunction

   function automatic logic [BytesW-1:0] next_bytes();
      logic [63:0] cap;
      cap = (cfg_rate == '0) ? 64'd2 : 64'(cfg_rate) * 64'd2;
      if (cap > 64'(RegMax)) cap = 64'(RegMax);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return $urandom;
         default: return $urandom_range(0, cap[31:0]);
      endcase
   endfunction

   function automatic logic [TicksW-1:0] next_elapsed();
      logic [63:0] cap;
      cap = (cfg_period == '0) ? 64'd2 : 64'(cfg_period) * 64'd2;
      if (cap > 64'(RegMax)) cap = 64'(RegMax);
      case ($urandom_range(0, 19))
         0: return '0;
         1: return TicksMax;
         2, 3: return TicksW'({$urandom, $urandom});
         default: begin
            tick_now = tick_now + TicksW'($urandom_range(0, cap[31:0]));
            return tick_now;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("ERROR: result %0d %s: got 0x%0h, expected 0x%0h",
               results_seen, what, got, want);
      err_count++;
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [RegW-1:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CsrBytesPerPeriod: cfg_rate = value;
         CsrPeriodTicks: cfg_period = value;
         default: ;
      endcase
   endtask

   task automatic drive_event(input logic [BytesW-1:0] nbytes,
                              input logic [TicksW-1:0] elapsed,
                              input logic pin, input delay_result_t want);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         req_chan.bytes_read = $urandom;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.bytes_read = nbytes;
      req_chan.elapsed_ticks = elapsed;
      pin_armed = pin;
      pin_result = want;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic run_phase(input logic [RegW-1:0] rate, input logic [RegW-1:0] period,
                            input int count, input int sidle, input int rstall,
                            input int hold);
      wait_drained();
      write_reg(CsrBytesPerPeriod, rate);
      write_reg(CsrPeriodTicks, period);
      settings_used++;
      send_idle_pct = sidle;
      recv_stall_pct = rstall;
      hold_left = hold;
      for (int i = 0; i < count; i++) begin
         drive_event(next_bytes(), next_elapsed(), 1'b0, '0);
      end
   endtask

   // The long hold-off makes the sender keep offering while the result waits.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_chan.ready = 1'b0;
      end else begin
         rsp_chan.ready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      delay_result_t r;
      if (!reset && req_chan.valid && req_chan.ready) begin
         r = limiter_predict(req_chan.bytes_read, req_chan.elapsed_ticks);
         events_taken++;
         if (r.delay_ticks != '0) delayed_events++;
         if (r.delay_ticks == TicksMax) ceiling_events++;
         if (pin_armed) begin
            r = pin_result;
            pin_armed = 1'b0;
         end
         pending_results.push_back(r);
      end
   end

   always @(posedge clock) begin
      delay_result_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("arrived with no event pending", 64'(rsp_chan.io_count), 64'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.delay_ticks !== want.delay_ticks)
               report_mismatch("delay_ticks", 64'(rsp_chan.delay_ticks),
                               64'(want.delay_ticks));
            if (rsp_chan.inconsistent !== want.inconsistent)
               report_mismatch("inconsistent", 64'(rsp_chan.inconsistent),
                               64'(want.inconsistent));
            if (rsp_chan.total_bytes !== want.total_bytes)
               report_mismatch("total_bytes", 64'(rsp_chan.total_bytes),
                               64'(want.total_bytes));
            if (rsp_chan.io_count !== want.io_count)
               report_mismatch("io_count", 64'(rsp_chan.io_count), 64'(want.io_count));
            if (rsp_chan.total_delay !== want.total_delay)
               report_mismatch("total_delay", 64'(rsp_chan.total_delay),
                               64'(want.total_delay));
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("ERROR: run did not finish within %0d cycles", CycleLimit);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CsrBytesPerPeriod;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.bytes_read = '0;
      req_chan.elapsed_ticks = '0;
      rsp_chan.ready = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == RowCsr) begin
            wait_drained();
            write_reg(directed_rows[i].index, directed_rows[i].value);
         end else begin
            drive_event(directed_rows[i].value, directed_rows[i].elapsed,
                        directed_rows[i].pinned, directed_rows[i].want);
         end
      end

      run_phase(RateReset, PeriodReset, 50, 0, 0, 0);
      run_phase('0, '0, 40, 52, 0, 0);
      run_phase(RegMax, RegMax, 40, 0, 52, HoldCycles);
      run_phase(RegW'($urandom_range(1, 5000)), RegW'($urandom_range(1, 100000)),
                40, 28, 28, 0);
      run_phase(RegW'($urandom), RegW'($urandom), 30, 0, 0, 0);
      // Rate of one byte over the longest period drives the delay total to its ceiling.
      run_phase(RegW'(1), RegMax, 260, 28, 28, 0);

      wait_drained();
      repeat (250) @(posedge clock);
      $display("Checked %0d results from %0d events over %0d random register settings.",
               results_seen, events_taken, settings_used);
      $display("%0d events were delayed, %0d of them at the delay ceiling.",
               delayed_events, ceiling_events);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/iorl_pkg.sv
rtl/iorl_if.sv
rtl/iorl_div.sv
rtl/io_rate_limiter_delay_unit.sv
tb/sv/tb.sv
